@@ src/mps_pkg.sv @@
// Shared types, constants and palette function for the Mandelbrot pixel shader.
package mps_pkg;

  localparam int PIXEL_W     = 12;
  localparam int SIDE_W      = 13;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 3;
  localparam int COLOR_W     = 8;
  localparam int FRAC_BITS   = 40;
  localparam int WORD_W      = 64;
  localparam int DIVIDEND_W  = SIDE_W + FRAC_BITS;

  localparam int DEFAULT_MAX_ITERATIONS = 128;
  localparam int DEFAULT_MAX_SIDE       = 4096;

  localparam logic [SIDE_W-1:0]     RESET_FRAME_WIDTH  = 13'd1024;
  localparam logic [SIDE_W-1:0]     RESET_FRAME_HEIGHT = 13'd768;
  localparam logic [CFG_DATA_W-1:0] RESET_ZOOM_SCALE   = 24'd16777215;
  localparam logic [CFG_DATA_W-1:0] RESET_COS_ROTATION = 24'd4194304;
  localparam logic [CFG_DATA_W-1:0] RESET_SIN_ROTATION = 24'd0;

  localparam logic signed [WORD_W-1:0] CENTRE_X   = -64'sd819136162693;
  localparam logic signed [WORD_W-1:0] CENTRE_Y   = 64'sd204509162766;
  localparam logic signed [WORD_W-1:0] ESCAPE_LIM = 64'sh0000_8000_0000_0000;
  localparam logic signed [WORD_W-1:0] ESCAPE_SQ  = 64'sh0040_0000_0000_0000;

  localparam logic signed [WORD_W-1:0] PI_Q30      = 64'sd3373259426;
  localparam logic signed [WORD_W-1:0] TWO_PI_Q30  = 64'sd6746518852;
  localparam logic [WORD_W-1:0]        HALF_PI_Q30 = 64'd1686629713;
  localparam logic [WORD_W-1:0]        ONE_Q30     = 64'd1073741824;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_ZOOM_SCALE   = 3'd2,
    REG_COS_ROTATION = 3'd3,
    REG_SIN_ROTATION = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {SH22, SH24, SH39, SH40} shift_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_DIV_X, OP_DIV_Y, OP_MUL, OP_POST, OP_ADVANCE, OP_FINISH
  } dp_op_t;

  typedef enum logic [3:0] {
    MUL_PX_CA, MUL_PY_SA, MUL_PX_SA, MUL_PY_CA, MUL_RX_Z, MUL_RY_Z,
    MUL_ZX_ZX, MUL_ZY_ZY, MUL_ZX_ZY, MUL_NX_NX, MUL_NY_NY
  } mul_sel_t;

  typedef enum logic [2:0] {
    POST_ACC_LOAD, POST_ACC_ADD, POST_SUB_RX, POST_ADD_RY,
    POST_CX, POST_CY, POST_NX, POST_NY
  } post_op_t;

  typedef enum logic [3:0] {
    STEP_PX_CA, STEP_PY_SA, STEP_PX_SA, STEP_PY_CA, STEP_RX_Z, STEP_RY_Z,
    STEP_ZX_ZX, STEP_ZY_ZY, STEP_ZX_ZY, STEP_NX_NX, STEP_NY_NY
  } step_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_DIVX, S_DIVY, S_MUL, S_MULW, S_BOUND, S_ESC, S_OUT
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t   op;
    mul_sel_t mul_sel;
    post_op_t post;
  } dp_cmd_t;

  typedef struct packed {
    logic outside;
    logic div_done;
    logic mul_done;
    logic bound_hit;
    logic escaped;
    logic last_iter;
    logic out_full;
  } dp_status_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    post_op_t post;
  } step_cmd_t;

  function automatic step_cmd_t step_cmd(input step_t step);
    step_cmd_t sc;
    unique case (step)
      STEP_PX_CA: sc = '{mul_sel: MUL_PX_CA, post: POST_ACC_LOAD};
      STEP_PY_SA: sc = '{mul_sel: MUL_PY_SA, post: POST_SUB_RX};
      STEP_PX_SA: sc = '{mul_sel: MUL_PX_SA, post: POST_ACC_LOAD};
      STEP_PY_CA: sc = '{mul_sel: MUL_PY_CA, post: POST_ADD_RY};
      STEP_RX_Z:  sc = '{mul_sel: MUL_RX_Z,  post: POST_CX};
      STEP_RY_Z:  sc = '{mul_sel: MUL_RY_Z,  post: POST_CY};
      STEP_ZX_ZX: sc = '{mul_sel: MUL_ZX_ZX, post: POST_ACC_LOAD};
      STEP_ZY_ZY: sc = '{mul_sel: MUL_ZY_ZY, post: POST_NX};
      STEP_ZX_ZY: sc = '{mul_sel: MUL_ZX_ZY, post: POST_NY};
      STEP_NX_NX: sc = '{mul_sel: MUL_NX_NX, post: POST_ACC_LOAD};
      STEP_NY_NY: sc = '{mul_sel: MUL_NY_NY, post: POST_ACC_ADD};
      default:    sc = '{mul_sel: MUL_PX_CA, post: POST_ACC_LOAD};
    endcase
    return sc;
  endfunction

  // palette byte for iteration count and channel phase in tenths of a radian
  function automatic logic [COLOR_W-1:0] palette_byte(input int unsigned count,
                                                      input int unsigned offset);
    logic [WORD_W-1:0]        tenths;
    logic [WORD_W-1:0]        a;
    logic [WORD_W-1:0]        x;
    logic [WORD_W-1:0]        x2;
    logic [WORD_W-1:0]        term;
    logic [WORD_W-1:0]        v;
    logic signed [WORD_W-1:0] sa;
    logic signed [WORD_W-1:0] sum;
    logic                     neg;
    tenths = 64'(30 + 3 * count + offset);
    a = (tenths * ONE_Q30 + 64'd5) / 64'd10;
    a = a % TWO_PI_Q30;
    sa = signed'(a);
    if (sa > PI_Q30) begin
      sa = sa - TWO_PI_Q30;
    end
    x = (sa < 0) ? 64'(-sa) : 64'(sa);
    neg = 1'b0;
    if (x > HALF_PI_Q30) begin
      x = 64'(PI_Q30) - x;
      neg = 1'b1;
    end
    x2 = (x * x) >> 30;
    term = ONE_Q30;
    sum = signed'(ONE_Q30);
    term = ((term * x2) >> 30) / 64'd2;
    sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd12;
    sum = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd30;
    sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd56;
    sum = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd90;
    sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd132;
    sum = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd182;
    sum = sum - signed'(term);
    if (sum < 0) begin
      sum = '0;
    end
    if (sum > signed'(ONE_Q30)) begin
      sum = signed'(ONE_Q30);
    end
    if (neg) begin
      sum = -sum;
    end
    v = ONE_Q30 + unsigned'(sum);
    return COLOR_W'((v * 64'd255) >> 31);
  endfunction

endpackage

@@ src/mps_if.sv @@
// Handshake interfaces for pixel, color and configuration words.
interface mps_pixel_if;
  logic                         valid;
  logic                         ready;
  logic [mps_pkg::PIXEL_W-1:0]  pixel_x;
  logic [mps_pkg::PIXEL_W-1:0]  pixel_y;
  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink (input valid, pixel_x, pixel_y, output ready);
endinterface

interface mps_color_if;
  logic                         valid;
  logic                         ready;
  logic [mps_pkg::COLOR_W-1:0]  red;
  logic [mps_pkg::COLOR_W-1:0]  green;
  logic [mps_pkg::COLOR_W-1:0]  blue;
  logic [mps_pkg::COLOR_W-1:0]  escape_count;
  modport source (output valid, red, green, blue, escape_count, input ready);
  modport sink (input valid, red, green, blue, escape_count, output ready);
endinterface

interface mps_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mps_pkg::CFG_INDEX_W-1:0] index;
  logic [mps_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ src/mps_mul.sv @@
// Signed multiply with truncating right shift, four 32x32 partial products.
module mps_mul (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [mps_pkg::WORD_W-1:0] a,
  input  logic [mps_pkg::WORD_W-1:0] b,
  input  mps_pkg::shift_t            shift,
  output logic                       busy,
  output logic                       done,
  output logic [mps_pkg::WORD_W-1:0] result
);

  localparam logic [2:0] PH_LAST = 3'd5;
  localparam logic [2:0] PH_MULS = 3'd4;

  logic [63:0]     ua;
  logic [63:0]     ub;
  logic            neg;
  mps_pkg::shift_t shift_r;
  logic [2:0]      ph;
  logic [63:0]     pp;
  logic [1:0]      ppos;
  logic [127:0]    acc;
  logic [31:0]     a_half;
  logic [31:0]     b_half;
  logic [127:0]    pp_wide;
  logic [127:0]    q;
  logic [62:0]     mag;
  logic [63:0]     res_next;

  always_comb begin
    a_half = ph[1] ? ua[63:32] : ua[31:0];
    b_half = ph[0] ? ub[63:32] : ub[31:0];
    case (ppos)
      2'd0:    pp_wide = {64'd0, pp};
      2'd1:    pp_wide = {32'd0, pp, 32'd0};
      default: pp_wide = {pp, 64'd0};
    endcase
    case (shift_r)
      mps_pkg::SH22: q = acc >> 22;
      mps_pkg::SH24: q = acc >> 24;
      mps_pkg::SH39: q = acc >> 39;
      default:       q = acc >> 40;
    endcase
    mag = (q > {65'd0, 1'b1, 62'd0}) ? {1'b1, 62'd0} : q[62:0];
    res_next = neg ? (64'd0 - {1'b0, mag}) : {1'b0, mag};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ua <= a[63] ? (64'd0 - a) : a;
      ub <= b[63] ? (64'd0 - b) : b;
      neg <= a[63] ^ b[63];
      shift_r <= shift;
      acc <= '0;
    end else if (busy) begin
      if (ph < PH_MULS) begin
        pp <= 64'(a_half) * 64'(b_half);
        ppos <= 2'(ph[1] + ph[0]);
      end
      if (ph != 3'd0 && ph <= PH_MULS) begin
        acc <= acc + pp_wide;
      end
      if (ph == PH_LAST) begin
        result <= res_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ph <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        ph <= '0;
      end else if (busy) begin
        ph <= ph + 3'd1;
        if (ph == PH_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ src/mps_div.sv @@
// Restoring divider for coordinate mapping, one quotient bit per cycle.
module mps_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [mps_pkg::SIDE_W-1:0] num_mag,
  input  logic                       neg,
  input  logic [mps_pkg::SIDE_W-1:0] divisor,
  output logic                       busy,
  output logic                       done,
  output logic [mps_pkg::WORD_W-1:0] quotient
);

  localparam int DW    = mps_pkg::DIVIDEND_W;
  localparam int SW    = mps_pkg::SIDE_W;
  localparam int CNT_W = $clog2(DW);

  logic [CNT_W-1:0] cnt;
  logic [SW-1:0]    rem;
  logic [DW-1:0]    dvd;
  logic [DW-1:0]    quo;
  logic [SW-1:0]    dvs;
  logic             neg_r;
  logic [SW:0]      trial;
  logic             fits;
  logic [SW-1:0]    rem_next;
  logic [DW-1:0]    quo_next;

  always_comb begin
    trial = {rem, dvd[DW-1]};
    fits = trial >= {1'b0, dvs};
    rem_next = fits ? SW'(trial - {1'b0, dvs}) : trial[SW-1:0];
    quo_next = {quo[DW-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= {num_mag, {mps_pkg::FRAC_BITS{1'b0}}};
      rem <= '0;
      quo <= '0;
      dvs <= divisor;
      neg_r <= neg;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= {dvd[DW-2:0], 1'b0};
      quo <= quo_next;
      if (cnt == CNT_W'(DW - 1)) begin
        quotient <= neg_r ? (64'd0 - 64'(quo_next)) : 64'(quo_next);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ src/mps_datapath.sv @@
// Datapath: configuration, coordinate mapping, orbit registers and color output.
module mps_datapath #(
  parameter int MAX_ITERATIONS = mps_pkg::DEFAULT_MAX_ITERATIONS,
  parameter int MAX_SIDE       = mps_pkg::DEFAULT_MAX_SIDE
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [mps_pkg::PIXEL_W-1:0] pixel_x,
  input  logic [mps_pkg::PIXEL_W-1:0] pixel_y,
  mps_cfg_if.sink                     cfg,
  mps_color_if.source                 color,
  input  mps_pkg::dp_cmd_t            cmd,
  output mps_pkg::dp_status_t         status
);

  localparam int CW    = $clog2(MAX_ITERATIONS + 1);
  localparam int PAL_N = MAX_ITERATIONS + 1;
  localparam int SW    = mps_pkg::SIDE_W;
  localparam int WW    = mps_pkg::WORD_W;

  logic [SW-1:0]                    frame_width;
  logic [SW-1:0]                    frame_height;
  logic [mps_pkg::CFG_DATA_W-1:0]   zoom_scale;
  logic [mps_pkg::CFG_DATA_W-1:0]   cos_rotation;
  logic [mps_pkg::CFG_DATA_W-1:0]   sin_rotation;

  logic [mps_pkg::PIXEL_W-1:0] x_reg;
  logic [mps_pkg::PIXEL_W-1:0] y_reg;
  logic [WW-1:0] px, py, rx, ry, cx, cy, zx, zy, nx, ny, acc;
  logic [CW-1:0] count;
  logic          div_dst_y;

  logic                        out_valid;
  logic [mps_pkg::COLOR_W-1:0] red, green, blue, escape_count;

  logic [SW-1:0] w_eff;
  logic [SW-1:0] h_eff;
  logic [SW:0]   diff_x;
  logic [SW:0]   diff_y;
  logic [SW:0]   diff;
  logic [SW-1:0] div_mag;
  logic [SW-1:0] div_size;
  logic          div_start;
  logic          div_busy;
  logic          div_done;
  logic [WW-1:0] div_q;

  logic            mul_start;
  logic [WW-1:0]   mul_a;
  logic [WW-1:0]   mul_b;
  mps_pkg::shift_t mul_shift;
  logic            mul_busy;
  logic            mul_done;
  logic [WW-1:0]   mres;
  logic [WW-1:0]   ca;
  logic [WW-1:0]   sa;
  logic [WW-1:0]   zoom;

  logic [mps_pkg::COLOR_W-1:0] pal_r [PAL_N];
  logic [mps_pkg::COLOR_W-1:0] pal_g [PAL_N];
  logic [mps_pkg::COLOR_W-1:0] pal_b [PAL_N];

  for (genvar g = 0; g < PAL_N; g++) begin : g_pal
    assign pal_r[g] = mps_pkg::palette_byte(g, 0);
    assign pal_g[g] = mps_pkg::palette_byte(g, 6);
    assign pal_b[g] = mps_pkg::palette_byte(g, 10);
  end

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= mps_pkg::RESET_FRAME_WIDTH;
      frame_height <= mps_pkg::RESET_FRAME_HEIGHT;
      zoom_scale <= mps_pkg::RESET_ZOOM_SCALE;
      cos_rotation <= mps_pkg::RESET_COS_ROTATION;
      sin_rotation <= mps_pkg::RESET_SIN_ROTATION;
    end else if (cfg.valid) begin
      unique case (mps_pkg::cfg_reg_t'(cfg.index))
        mps_pkg::REG_FRAME_WIDTH:  frame_width <= cfg.data[SW-1:0];
        mps_pkg::REG_FRAME_HEIGHT: frame_height <= cfg.data[SW-1:0];
        mps_pkg::REG_ZOOM_SCALE:   zoom_scale <= cfg.data;
        mps_pkg::REG_COS_ROTATION: cos_rotation <= cfg.data;
        mps_pkg::REG_SIN_ROTATION: sin_rotation <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = (32'(frame_width) > MAX_SIDE) ? SW'(MAX_SIDE) : frame_width;
    h_eff = (32'(frame_height) > MAX_SIDE) ? SW'(MAX_SIDE) : frame_height;
    diff_x = {1'b0, x_reg, 1'b0} - {1'b0, w_eff};
    diff_y = {1'b0, y_reg, 1'b0} - {1'b0, h_eff};
    diff = (cmd.op == mps_pkg::OP_DIV_Y) ? diff_y : diff_x;
    div_mag = diff[SW] ? SW'(0 - diff) : diff[SW-1:0];
    div_size = (cmd.op == mps_pkg::OP_DIV_Y) ? h_eff : w_eff;
    div_start = (cmd.op == mps_pkg::OP_DIV_X) || (cmd.op == mps_pkg::OP_DIV_Y);

    ca = {{(WW - mps_pkg::CFG_DATA_W){cos_rotation[mps_pkg::CFG_DATA_W-1]}}, cos_rotation};
    sa = {{(WW - mps_pkg::CFG_DATA_W){sin_rotation[mps_pkg::CFG_DATA_W-1]}}, sin_rotation};
    zoom = {{(WW - mps_pkg::CFG_DATA_W){1'b0}}, zoom_scale};
    mul_start = (cmd.op == mps_pkg::OP_MUL);
    mul_a = px;
    mul_b = ca;
    mul_shift = mps_pkg::SH40;
    case (cmd.mul_sel)
      mps_pkg::MUL_PX_CA: begin mul_a = px; mul_b = ca; mul_shift = mps_pkg::SH22; end
      mps_pkg::MUL_PY_SA: begin mul_a = py; mul_b = sa; mul_shift = mps_pkg::SH22; end
      mps_pkg::MUL_PX_SA: begin mul_a = px; mul_b = sa; mul_shift = mps_pkg::SH22; end
      mps_pkg::MUL_PY_CA: begin mul_a = py; mul_b = ca; mul_shift = mps_pkg::SH22; end
      mps_pkg::MUL_RX_Z:  begin mul_a = rx; mul_b = zoom; mul_shift = mps_pkg::SH24; end
      mps_pkg::MUL_RY_Z:  begin mul_a = ry; mul_b = zoom; mul_shift = mps_pkg::SH24; end
      mps_pkg::MUL_ZX_ZX: begin mul_a = zx; mul_b = zx; end
      mps_pkg::MUL_ZY_ZY: begin mul_a = zy; mul_b = zy; end
      mps_pkg::MUL_ZX_ZY: begin mul_a = zx; mul_b = zy; mul_shift = mps_pkg::SH39; end
      mps_pkg::MUL_NX_NX: begin mul_a = nx; mul_b = nx; end
      mps_pkg::MUL_NY_NY: begin mul_a = ny; mul_b = ny; end
      default: ;
    endcase
  end

  mps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num_mag  (div_mag),
    .neg      (diff[SW]),
    .divisor  (div_size),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  mps_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .shift  (mul_shift),
    .busy   (mul_busy),
    .done   (mul_done),
    .result (mres)
  );

  always_ff @(posedge clk) begin
    if (div_done) begin
      if (div_dst_y) begin
        py <= div_q;
      end else begin
        px <= div_q;
      end
    end
    unique case (cmd.op)
      mps_pkg::OP_LOAD: begin
        x_reg <= pixel_x;
        y_reg <= pixel_y;
        zx <= '0;
        zy <= '0;
        count <= '0;
      end
      mps_pkg::OP_DIV_X: div_dst_y <= 1'b0;
      mps_pkg::OP_DIV_Y: div_dst_y <= 1'b1;
      mps_pkg::OP_POST: begin
        case (cmd.post)
          mps_pkg::POST_ACC_LOAD: acc <= mres;
          mps_pkg::POST_ACC_ADD:  acc <= acc + mres;
          mps_pkg::POST_SUB_RX:   rx <= acc - mres;
          mps_pkg::POST_ADD_RY:   ry <= acc + mres;
          mps_pkg::POST_CX:       cx <= mps_pkg::CENTRE_X + mres;
          mps_pkg::POST_CY:       cy <= mps_pkg::CENTRE_Y + mres;
          mps_pkg::POST_NX:       nx <= acc - mres + cx;
          default:                ny <= mres + cy;
        endcase
      end
      mps_pkg::OP_ADVANCE: begin
        zx <= nx;
        zy <= ny;
        count <= count + 1'b1;
      end
      mps_pkg::OP_FINISH: begin
        red <= pal_r[count];
        green <= pal_g[count];
        blue <= pal_b[count];
        escape_count <= (32'(count) > 32'd255) ? 8'hFF : 8'(count);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == mps_pkg::OP_FINISH) begin
      out_valid <= 1'b1;
    end else if (color.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign color.valid = out_valid;
  assign color.red = red;
  assign color.green = green;
  assign color.blue = blue;
  assign color.escape_count = escape_count;

  always_comb begin
    status.outside = ({1'b0, x_reg} >= w_eff) || ({1'b0, y_reg} >= h_eff);
    status.div_done = div_done;
    status.mul_done = mul_done;
    status.bound_hit = ($signed(nx) > mps_pkg::ESCAPE_LIM) || ($signed(nx) < -mps_pkg::ESCAPE_LIM)
                    || ($signed(ny) > mps_pkg::ESCAPE_LIM) || ($signed(ny) < -mps_pkg::ESCAPE_LIM);
    status.escaped = $signed(acc) > mps_pkg::ESCAPE_SQ;
    status.last_iter = (count == CW'(MAX_ITERATIONS - 1));
    status.out_full = out_valid && !color.ready;
  end

`ifndef SYNTH
  assert property (@(posedge clk) disable iff (rst)
    (cmd.op == mps_pkg::OP_FINISH) |-> !(out_valid && !color.ready))
    else $error("finish overwrites a held color word");
  assert property (@(posedge clk) disable iff (rst)
    (cmd.op == mps_pkg::OP_MUL) |-> !mul_busy)
    else $error("multiplier restarted while busy");
  assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");
  assert property (@(posedge clk) disable iff (rst)
    (cmd.op == mps_pkg::OP_ADVANCE) |-> (32'(count) < MAX_ITERATIONS))
    else $error("iteration count runs past the limit");
`endif

endmodule

@@ src/mps_ctrl.sv @@
// Controller: sequences mapping, rotation, orbit iterations and color output.
module mps_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mps_pkg::dp_status_t status,
  output mps_pkg::dp_cmd_t    cmd
);

  mps_pkg::ctrl_state_t state, state_next;
  mps_pkg::step_t       step, step_next;
  mps_pkg::step_cmd_t   sc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mps_pkg::S_IDLE;
      step <= mps_pkg::STEP_PX_CA;
    end else begin
      state <= state_next;
      step <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next = step;
    in_ready = 1'b0;
    sc = mps_pkg::step_cmd(step);
    cmd = '{op: mps_pkg::OP_NOP, mul_sel: sc.mul_sel, post: sc.post};
    unique case (state)
      mps_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = mps_pkg::OP_LOAD;
          state_next = mps_pkg::S_CHECK;
        end
      end
      mps_pkg::S_CHECK: begin
        if (status.outside) begin
          state_next = mps_pkg::S_IDLE;
        end else begin
          cmd.op = mps_pkg::OP_DIV_X;
          state_next = mps_pkg::S_DIVX;
        end
      end
      mps_pkg::S_DIVX: begin
        if (status.div_done) begin
          cmd.op = mps_pkg::OP_DIV_Y;
          state_next = mps_pkg::S_DIVY;
        end
      end
      mps_pkg::S_DIVY: begin
        if (status.div_done) begin
          step_next = mps_pkg::STEP_PX_CA;
          state_next = mps_pkg::S_MUL;
        end
      end
      mps_pkg::S_MUL: begin
        cmd.op = mps_pkg::OP_MUL;
        state_next = mps_pkg::S_MULW;
      end
      mps_pkg::S_MULW: begin
        if (status.mul_done) begin
          cmd.op = mps_pkg::OP_POST;
          if (step == mps_pkg::STEP_ZX_ZY) begin
            state_next = mps_pkg::S_BOUND;
          end else if (step == mps_pkg::STEP_NY_NY) begin
            state_next = mps_pkg::S_ESC;
          end else begin
            step_next = mps_pkg::step_t'(step + 4'd1);
            state_next = mps_pkg::S_MUL;
          end
        end
      end
      mps_pkg::S_BOUND: begin
        if (status.bound_hit) begin
          state_next = mps_pkg::S_OUT;
        end else begin
          step_next = mps_pkg::STEP_NX_NX;
          state_next = mps_pkg::S_MUL;
        end
      end
      mps_pkg::S_ESC: begin
        if (status.escaped) begin
          state_next = mps_pkg::S_OUT;
        end else begin
          cmd.op = mps_pkg::OP_ADVANCE;
          if (status.last_iter) begin
            state_next = mps_pkg::S_OUT;
          end else begin
            step_next = mps_pkg::STEP_ZX_ZX;
            state_next = mps_pkg::S_MUL;
          end
        end
      end
      mps_pkg::S_OUT: begin
        if (!status.out_full) begin
          cmd.op = mps_pkg::OP_FINISH;
          state_next = mps_pkg::S_IDLE;
        end
      end
      default: state_next = mps_pkg::S_IDLE;
    endcase
  end

endmodule

@@ src/mandelbrot_pixel_shader.sv @@
// Mandelbrot escape-time pixel shader with cosine palette.
//
// Channels: pixel (sink) takes one pixel_x/pixel_y word; color (source)
// returns red, green, blue and escape_count; cfg (sink, always ready)
// writes frame_width, frame_height, zoom_scale, cos_rotation and
// sin_rotation by index 0 to 4. Write cfg only while the block is idle.
// One pixel is worked at a time. A pixel outside the frame gives no word.
// Otherwise the two 53-step coordinate divisions run first, then rotation
// and zoom, then the orbit iterations: every complex product goes through
// one shared unit that forms four 32x32 partial products, five products
// a full iteration.
// The color word sits in an output register; the next pixel is taken
// while it waits. If the receiver stalls, a finished pixel holds in the
// controller until the register frees.
// Reset restores the configuration defaults and empties the output.
module mandelbrot_pixel_shader #(
  parameter int MAX_ITERATIONS = mps_pkg::DEFAULT_MAX_ITERATIONS,
  parameter int MAX_SIDE       = mps_pkg::DEFAULT_MAX_SIDE
) (
  input  logic        clk,
  input  logic        rst,
  mps_pixel_if.sink   pixel,
  mps_color_if.source color,
  mps_cfg_if.sink     cfg
);

  mps_pkg::dp_cmd_t    cmd;
  mps_pkg::dp_status_t status;

  mps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pixel.valid),
    .in_ready (pixel.ready),
    .status   (status),
    .cmd      (cmd)
  );

  mps_datapath #(
    .MAX_ITERATIONS (MAX_ITERATIONS),
    .MAX_SIDE       (MAX_SIDE)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .pixel_x (pixel.pixel_x),
    .pixel_y (pixel.pixel_y),
    .cfg     (cfg),
    .color   (color),
    .cmd     (cmd),
    .status  (status)
  );

endmodule
